/* hdl/skti_pkg.sv */
// Shared types and constants for the sorted key table.
// Used by skti_cell, skti_group and sorted_key_table_insert; depends on nothing.
package skti_pkg;

    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_KEY_BITS      = 16;
    localparam int RED_GROUP         = 16;

    localparam int LINE_W = 24;
    localparam int MOD_W  = 16;
    localparam int OCC_W  = 16;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_RED1,
        S_RED2
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] text_id;
        logic [15:0] context_id;
        logic [23:0] src_line;
        logic [15:0] module_id;
        logic [7:0]  read_index;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  entry_index;
        logic        was_new;
        logic [15:0] occurrences;
        logic [15:0] key_text;
        logic [15:0] key_context;
        logic [23:0] first_line;
        logic [15:0] first_module;
        logic [8:0]  entry_total;
    } out_t;

    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic is_read;
        logic grow;
        logic bump;
    } cell_ctrl_t;

endpackage

/* hdl/sorted_key_table_insert.sv */
// Sorted key table: a chain of entry cells kept in ascending (text, context)
// order, with insert-or-count and indexed read. Depends on skti_pkg,
// skti_cell and skti_group.
//
// Input channel in_valid/in_ready/in_data carries one command per transfer:
// an insert of one key occurrence or a read of the entry at read_index.
// Output channel out_valid/out_ready/out_data returns exactly one result per
// command, in order.
// Each command's result is presented after these steps: compare in
// every cell against the broadcast key, shift or count in the chain, then a
// two-level registered OR tree over groups of 16 cells picks out the touched
// entry. A new command is taken only after the previous one has left its last step.
// in_ready is high only between commands, so one command is in flight at a
// time; the next transfer can happen while the previous result still sits in
// the output register.
// When the receiver stalls, the finished result is held in the last step until
// the output register frees up; no command is taken meanwhile.
// Reset empties the table (entry count zero) and drops any command in flight.
// Entry storage is not cleared; only positions below the count are used.
module sorted_key_table_insert #(
    parameter int TABLE_ENTRIES = skti_pkg::DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = skti_pkg::DEF_KEY_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  skti_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output skti_pkg::out_t out_data
);
    import skti_pkg::*;

    localparam int GROUP   = RED_GROUP;
    localparam int NGROUPS = (TABLE_ENTRIES + GROUP - 1) / GROUP;
    localparam int NPAD    = NGROUPS * GROUP;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    state_t           state_reg;
    state_t           state_next;
    in_t              cmd_reg;
    logic [CNT_W-1:0] count_reg;
    logic             grow_reg;
    logic             drop_reg;
    logic             out_valid_reg;
    out_t             out_reg;

    cell_ctrl_t          ctrl;
    logic                is_read;
    logic                full;
    logic                eq_any;
    logic                grow;
    logic                drop;
    logic                out_load;
    logic [KEY_BITS-1:0] key_text;
    logic [KEY_BITS-1:0] key_ctx;

    logic [NPAD-1:0]                ge_v;
    logic [NPAD-1:0]                eq_v;
    logic [NPAD-1:0]                sel_v;
    logic [NPAD-1:0][KEY_BITS-1:0]  text_v;
    logic [NPAD-1:0][KEY_BITS-1:0]  ctx_v;
    logic [NPAD-1:0][LINE_W-1:0]    line_v;
    logic [NPAD-1:0][MOD_W-1:0]     mod_v;
    logic [NPAD-1:0][OCC_W-1:0]     occ_v;
    logic [NPAD-1:0][KEY_BITS-1:0]  ftext_v;
    logic [NPAD-1:0][KEY_BITS-1:0]  fctx_v;
    logic [NPAD-1:0][LINE_W-1:0]    fline_v;
    logic [NPAD-1:0][MOD_W-1:0]     fmod_v;
    logic [NPAD-1:0][OCC_W-1:0]     focc_v;

    logic [NGROUPS-1:0]                g_eq;
    logic [NGROUPS-1:0]                g_hit;
    logic [NGROUPS-1:0][IDX_W-1:0]     g_index;
    logic [NGROUPS-1:0][KEY_BITS-1:0]  g_text;
    logic [NGROUPS-1:0][KEY_BITS-1:0]  g_ctx;
    logic [NGROUPS-1:0][LINE_W-1:0]    g_line;
    logic [NGROUPS-1:0][MOD_W-1:0]     g_mod;
    logic [NGROUPS-1:0][OCC_W-1:0]     g_occ;

    logic                hit_all;
    logic [IDX_W-1:0]    idx_all;
    logic [KEY_BITS-1:0] text_all;
    logic [KEY_BITS-1:0] ctx_all;
    logic [LINE_W-1:0]   line_all;
    logic [MOD_W-1:0]    mod_all;
    logic [OCC_W-1:0]    occ_all;
    out_t                res;

    assign key_text = KEY_BITS'(cmd_reg.text_id);
    assign key_ctx  = KEY_BITS'(cmd_reg.context_id);
    assign is_read  = (cmd_reg.cmd == CMD_READ);
    assign full     = (count_reg == FULL_COUNT);
    assign eq_any   = |g_eq;
    assign grow     = !is_read && !eq_any && !full;
    assign drop     = !is_read && !eq_any && full;

    assign ctrl.cmp_en  = (state_reg == S_CMP);
    assign ctrl.upd_en  = (state_reg == S_UPD);
    assign ctrl.is_read = is_read;
    assign ctrl.grow    = (state_reg == S_UPD) && grow;
    assign ctrl.bump    = (state_reg == S_UPD) && !is_read && eq_any;

    genvar gi;
    generate
        for (gi = 0; gi < NPAD; gi++)
        begin : g_cell
            if (gi < TABLE_ENTRIES)
            begin : g_live
                logic                prev_ge;
                logic [KEY_BITS-1:0] prev_text;
                logic [KEY_BITS-1:0] prev_ctx;
                logic [LINE_W-1:0]   prev_line;
                logic [MOD_W-1:0]    prev_mod;
                logic [OCC_W-1:0]    prev_occ;

                if (gi == 0)
                begin : g_head
                    assign prev_ge   = 1'b0;
                    assign prev_text = '0;
                    assign prev_ctx  = '0;
                    assign prev_line = '0;
                    assign prev_mod  = '0;
                    assign prev_occ  = '0;
                end
                else
                begin : g_link
                    assign prev_ge   = ge_v[gi-1];
                    assign prev_text = ftext_v[gi-1];
                    assign prev_ctx  = fctx_v[gi-1];
                    assign prev_line = fline_v[gi-1];
                    assign prev_mod  = fmod_v[gi-1];
                    assign prev_occ  = focc_v[gi-1];
                end

                skti_cell #(
                    .KEY_BITS (KEY_BITS),
                    .CNT_W    (CNT_W),
                    .INDEX    (gi)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .key_text   (key_text),
                    .key_ctx    (key_ctx),
                    .new_line   (cmd_reg.src_line),
                    .new_mod    (cmd_reg.module_id),
                    .read_index (cmd_reg.read_index),
                    .count      (count_reg),
                    .prev_ge    (prev_ge),
                    .prev_text  (prev_text),
                    .prev_ctx   (prev_ctx),
                    .prev_line  (prev_line),
                    .prev_mod   (prev_mod),
                    .prev_occ   (prev_occ),
                    .ge         (ge_v[gi]),
                    .eq         (eq_v[gi]),
                    .sel        (sel_v[gi]),
                    .text       (text_v[gi]),
                    .ctx        (ctx_v[gi]),
                    .line       (line_v[gi]),
                    .mod        (mod_v[gi]),
                    .occ        (occ_v[gi]),
                    .fwd_text   (ftext_v[gi]),
                    .fwd_ctx    (fctx_v[gi]),
                    .fwd_line   (fline_v[gi]),
                    .fwd_mod    (fmod_v[gi]),
                    .fwd_occ    (focc_v[gi])
                );
            end
            else
            begin : g_pad
                assign ge_v[gi]    = 1'b1;
                assign eq_v[gi]    = 1'b0;
                assign sel_v[gi]   = 1'b0;
                assign text_v[gi]  = '0;
                assign ctx_v[gi]   = '0;
                assign line_v[gi]  = '0;
                assign mod_v[gi]   = '0;
                assign occ_v[gi]   = '0;
                assign ftext_v[gi] = '0;
                assign fctx_v[gi]  = '0;
                assign fline_v[gi] = '0;
                assign fmod_v[gi]  = '0;
                assign focc_v[gi]  = '0;
            end
        end

        for (gi = 0; gi < NGROUPS; gi++)
        begin : g_grp
            skti_group #(
                .GROUP    (GROUP),
                .BASE     (gi * GROUP),
                .KEY_BITS (KEY_BITS),
                .IDX_W    (IDX_W)
            ) u_group (
                .clk      (clk),
                .rst_n    (rst_n),
                .eq_en    (ctrl.cmp_en),
                .red_en   (state_reg == S_RED1),
                .eq       (eq_v[gi*GROUP +: GROUP]),
                .sel      (sel_v[gi*GROUP +: GROUP]),
                .text     (text_v[gi*GROUP +: GROUP]),
                .ctx      (ctx_v[gi*GROUP +: GROUP]),
                .line     (line_v[gi*GROUP +: GROUP]),
                .mod      (mod_v[gi*GROUP +: GROUP]),
                .occ      (occ_v[gi*GROUP +: GROUP]),
                .eq_any   (g_eq[gi]),
                .hit      (g_hit[gi]),
                .index    (g_index[gi]),
                .text_sel (g_text[gi]),
                .ctx_sel  (g_ctx[gi]),
                .line_sel (g_line[gi]),
                .mod_sel  (g_mod[gi]),
                .occ_sel  (g_occ[gi])
            );
        end
    endgenerate

    always_comb
    begin
        idx_all  = '0;
        text_all = '0;
        ctx_all  = '0;
        line_all = '0;
        mod_all  = '0;
        occ_all  = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            idx_all  = idx_all  | g_index[g];
            text_all = text_all | g_text[g];
            ctx_all  = ctx_all  | g_ctx[g];
            line_all = line_all | g_line[g];
            mod_all  = mod_all  | g_mod[g];
            occ_all  = occ_all  | g_occ[g];
        end
    end

    assign hit_all = |g_hit;

    always_comb
    begin
        res             = '0;
        res.entry_total = 9'(count_reg);
        if (is_read)
        begin
            res.status      = hit_all ? STAT_OK : STAT_RANGE;
            res.entry_index = cmd_reg.read_index;
        end
        else
        begin
            res.status      = drop_reg ? STAT_FULL : STAT_OK;
            res.entry_index = hit_all ? 8'(idx_all) : 8'(TABLE_ENTRIES);
            res.was_new     = grow_reg;
        end
        if (hit_all && !(!is_read && drop_reg))
        begin
            res.occurrences  = occ_all;
            res.key_text     = 16'(text_all);
            res.key_context  = 16'(ctx_all);
            res.first_line   = line_all;
            res.first_module = mod_all;
        end
    end

    assign out_load = (state_reg == S_RED2) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:  state_next = S_UPD;
            S_UPD:  state_next = S_RED1;
            S_RED1: state_next = S_RED2;
            S_RED2:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            grow_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPD)
            begin
                grow_reg <= grow;
                drop_reg <= drop;
                if (grow)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_data;
        end
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_UPD && $past(grow)))
        else $error("entry count changed outside a growing insert");

    a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED1) |-> $onehot0(sel_v))
        else $error("more than one cell selected");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == STAT_FULL) |-> (count_reg == FULL_COUNT))
        else $error("full status with free entries");

    a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.was_new) |->
            (out_reg.status == STAT_OK && out_reg.occurrences == 16'd1))
        else $error("new entry result with bad status or count");
`endif

endmodule

/* hdl/skti_cell.sv */
// One table entry of the sorted chain: key, first line, module and count.
// Compares against the broadcast key and shifts from its left neighbor on insert.
// Depends on skti_pkg.
module skti_cell #(
    parameter int KEY_BITS = skti_pkg::DEF_KEY_BITS,
    parameter int CNT_W    = 9,
    parameter int INDEX    = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  skti_pkg::cell_ctrl_t         ctrl,
    input  logic [KEY_BITS-1:0]          key_text,
    input  logic [KEY_BITS-1:0]          key_ctx,
    input  logic [skti_pkg::LINE_W-1:0]  new_line,
    input  logic [skti_pkg::MOD_W-1:0]   new_mod,
    input  logic [7:0]                   read_index,
    input  logic [CNT_W-1:0]             count,
    input  logic                         prev_ge,
    input  logic [KEY_BITS-1:0]          prev_text,
    input  logic [KEY_BITS-1:0]          prev_ctx,
    input  logic [skti_pkg::LINE_W-1:0]  prev_line,
    input  logic [skti_pkg::MOD_W-1:0]   prev_mod,
    input  logic [skti_pkg::OCC_W-1:0]   prev_occ,
    output logic                         ge,
    output logic                         eq,
    output logic                         sel,
    output logic [KEY_BITS-1:0]          text,
    output logic [KEY_BITS-1:0]          ctx,
    output logic [skti_pkg::LINE_W-1:0]  line,
    output logic [skti_pkg::MOD_W-1:0]   mod,
    output logic [skti_pkg::OCC_W-1:0]   occ,
    output logic [KEY_BITS-1:0]          fwd_text,
    output logic [KEY_BITS-1:0]          fwd_ctx,
    output logic [skti_pkg::LINE_W-1:0]  fwd_line,
    output logic [skti_pkg::MOD_W-1:0]   fwd_mod,
    output logic [skti_pkg::OCC_W-1:0]   fwd_occ
);
    import skti_pkg::*;

    localparam logic [CNT_W-1:0] POS      = CNT_W'(INDEX);
    localparam bit               READABLE = (INDEX < 256);

    logic [KEY_BITS-1:0] text_reg;
    logic [KEY_BITS-1:0] ctx_reg;
    logic [LINE_W-1:0]   line_reg;
    logic [MOD_W-1:0]    mod_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic                ge_reg;
    logic                eq_reg;
    logic                sel_reg;

    logic valid;
    logic lt_key;
    logic eq_key;
    logic at_pos;
    logic read_hit;

    assign valid  = (POS < count);
    assign eq_key = valid && (text_reg == key_text) && (ctx_reg == key_ctx);
    assign lt_key = valid && ((text_reg < key_text) ||
                              ((text_reg == key_text) && (ctx_reg < key_ctx)));
    assign at_pos   = ge_reg && !prev_ge;
    assign read_hit = READABLE && valid && (read_index == 8'(INDEX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.cmp_en)
            begin
                ge_reg <= !lt_key;
                eq_reg <= eq_key;
            end
            if (ctrl.upd_en)
            begin
                sel_reg <= ctrl.is_read ? read_hit : at_pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.grow)
        begin
            if (prev_ge)
            begin
                text_reg <= prev_text;
                ctx_reg  <= prev_ctx;
                line_reg <= prev_line;
                mod_reg  <= prev_mod;
                occ_reg  <= prev_occ;
            end
            else if (at_pos)
            begin
                text_reg <= key_text;
                ctx_reg  <= key_ctx;
                line_reg <= new_line;
                mod_reg  <= new_mod;
                occ_reg  <= OCC_W'(1);
            end
        end
        else if (ctrl.bump && eq_reg && (occ_reg != '1))
        begin
            occ_reg <= occ_reg + OCC_W'(1);
        end
    end

    assign ge   = ge_reg;
    assign eq   = eq_key;
    assign sel  = sel_reg;
    assign text = sel_reg ? text_reg : '0;
    assign ctx  = sel_reg ? ctx_reg  : '0;
    assign line = sel_reg ? line_reg : '0;
    assign mod  = sel_reg ? mod_reg  : '0;
    assign occ  = sel_reg ? occ_reg  : '0;

    assign fwd_text = text_reg;
    assign fwd_ctx  = ctx_reg;
    assign fwd_line = line_reg;
    assign fwd_mod  = mod_reg;
    assign fwd_occ  = occ_reg;

endmodule

/* hdl/skti_group.sv */
// Registered first level of the OR trees over a group of cells: match flag
// and the record and position of the selected cell. Depends on skti_pkg.
module skti_group #(
    parameter int GROUP    = skti_pkg::RED_GROUP,
    parameter int BASE     = 0,
    parameter int KEY_BITS = skti_pkg::DEF_KEY_BITS,
    parameter int IDX_W    = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   eq_en,
    input  logic                                   red_en,
    input  logic [GROUP-1:0]                       eq,
    input  logic [GROUP-1:0]                       sel,
    input  logic [GROUP-1:0][KEY_BITS-1:0]         text,
    input  logic [GROUP-1:0][KEY_BITS-1:0]         ctx,
    input  logic [GROUP-1:0][skti_pkg::LINE_W-1:0] line,
    input  logic [GROUP-1:0][skti_pkg::MOD_W-1:0]  mod,
    input  logic [GROUP-1:0][skti_pkg::OCC_W-1:0]  occ,
    output logic                                   eq_any,
    output logic                                   hit,
    output logic [IDX_W-1:0]                       index,
    output logic [KEY_BITS-1:0]                    text_sel,
    output logic [KEY_BITS-1:0]                    ctx_sel,
    output logic [skti_pkg::LINE_W-1:0]            line_sel,
    output logic [skti_pkg::MOD_W-1:0]             mod_sel,
    output logic [skti_pkg::OCC_W-1:0]             occ_sel
);
    import skti_pkg::*;

    logic                eq_any_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    index_reg;
    logic [KEY_BITS-1:0] text_reg;
    logic [KEY_BITS-1:0] ctx_reg;
    logic [LINE_W-1:0]   line_reg;
    logic [MOD_W-1:0]    mod_reg;
    logic [OCC_W-1:0]    occ_reg;

    logic [IDX_W-1:0]    index_c;
    logic [KEY_BITS-1:0] text_c;
    logic [KEY_BITS-1:0] ctx_c;
    logic [LINE_W-1:0]   line_c;
    logic [MOD_W-1:0]    mod_c;
    logic [OCC_W-1:0]    occ_c;

    always_comb
    begin
        index_c = '0;
        text_c  = '0;
        ctx_c   = '0;
        line_c  = '0;
        mod_c   = '0;
        occ_c   = '0;
        for (int j = 0; j < GROUP; j++)
        begin
            if (sel[j])
            begin
                index_c = index_c | IDX_W'(BASE + j);
            end
            text_c = text_c | text[j];
            ctx_c  = ctx_c  | ctx[j];
            line_c = line_c | line[j];
            mod_c  = mod_c  | mod[j];
            occ_c  = occ_c  | occ[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_any_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (eq_en)
            begin
                eq_any_reg <= |eq;
            end
            if (red_en)
            begin
                hit_reg <= |sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (red_en)
        begin
            index_reg <= index_c;
            text_reg  <= text_c;
            ctx_reg   <= ctx_c;
            line_reg  <= line_c;
            mod_reg   <= mod_c;
            occ_reg   <= occ_c;
        end
    end

    assign eq_any   = eq_any_reg;
    assign hit      = hit_reg;
    assign index    = index_reg;
    assign text_sel = text_reg;
    assign ctx_sel  = ctx_reg;
    assign line_sel = line_reg;
    assign mod_sel  = mod_reg;
    assign occ_sel  = occ_reg;

endmodule
